// File: rtl/imm_pkg.sv
// Shared types and constants of the integer matrix multiply block.
// No dependencies; used by imm_ctrl, imm_datapath and integer_matrix_multiply.
`timescale 1ns / 1ps
`default_nettype none

package imm_pkg;

    localparam int IDX_W  = 3;   // row, column and inner index
    localparam int DIM_W  = 4;   // matrix_size register
    localparam int DATA_W = 32;  // matrix element
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD_LEFT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_RIGHT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE    = 2'd2;

    // Cycles spent after the last read so the datapath pipeline empties.
    localparam logic [1:0] DRAIN_CYCLES = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPUTE,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic             wr_left;   // write element into left store
        logic             wr_right;  // write element into right store
        logic             rd_valid;  // read one product term
        logic             acc_first; // first term of a dot product
        logic             acc_end;   // final term of a dot product
        logic             last_elem; // final term of the whole matrix
        logic [IDX_W-1:0] ci;
        logic [IDX_W-1:0] cj;
        logic [IDX_W-1:0] ck;
    } t_dp_cmd;

endpackage

`default_nettype wire

// File: rtl/imm_ctrl.sv
// Controller of the matrix multiply: size register, loop counters, state machine.
// Depends on imm_pkg; drives imm_datapath through a t_dp_cmd command.
`timescale 1ns / 1ps
`default_nettype none

module imm_ctrl #(
    parameter int MAX_DIM = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [imm_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [imm_pkg::IDX_W-1:0]    i_row,
    input  wire logic [imm_pkg::IDX_W-1:0]    i_col,
    input  wire logic                         i_cfg_we,
    input  wire logic [imm_pkg::DIM_W-1:0]    i_cfg_data,
    output logic                              o_busy,
    output imm_pkg::t_dp_cmd                  o_cmd
);

    localparam logic [imm_pkg::DIM_W-1:0] MAX_DIM_V = imm_pkg::DIM_W'(MAX_DIM);

    imm_pkg::t_state             r_state, n_state;
    logic [imm_pkg::DIM_W-1:0]   r_size;
    logic [imm_pkg::DIM_W-1:0]   r_dim, n_dim;
    logic [imm_pkg::IDX_W-1:0]   r_i, n_i, r_j, n_j, r_k, n_k;
    logic [1:0]                  r_drain, n_drain;

    logic [imm_pkg::DIM_W-1:0]   act_dim;
    logic [imm_pkg::DIM_W-1:0]   dim_m1;
    logic [imm_pkg::IDX_W-1:0]   dim_end;
    logic                        in_range;
    logic                        k_end, j_end, i_end;

    // Clamp the size register into 1..MAX_DIM.
    always_comb begin
        if (r_size == '0) begin
            act_dim = imm_pkg::DIM_W'(1);
        end else if (r_size > MAX_DIM_V) begin
            act_dim = MAX_DIM_V;
        end else begin
            act_dim = r_size;
        end
    end

    assign dim_m1   = r_dim - imm_pkg::DIM_W'(1);
    assign dim_end  = dim_m1[imm_pkg::IDX_W-1:0];
    assign in_range = ({1'b0, i_row} < MAX_DIM_V) && ({1'b0, i_col} < MAX_DIM_V);
    assign k_end    = (r_k == dim_end);
    assign j_end    = (r_j == dim_end);
    assign i_end    = (r_i == dim_end);
    assign o_busy   = (r_state != imm_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= imm_pkg::ST_IDLE;
            r_size  <= MAX_DIM_V;
            r_dim   <= MAX_DIM_V;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_dim   <= n_dim;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_drain <= n_drain;
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_dim   = r_dim;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_drain = r_drain;
        o_cmd           = '0;
        o_cmd.ci        = r_i;
        o_cmd.cj        = r_j;
        o_cmd.ck        = r_k;
        unique case (r_state)
            imm_pkg::ST_IDLE: begin
                if (i_start) begin
                    unique if (i_mode == imm_pkg::MODE_COMPUTE) begin
                        n_dim   = act_dim;
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                        n_state = imm_pkg::ST_COMPUTE;
                    end else if (i_mode == imm_pkg::MODE_LOAD_LEFT) begin
                        o_cmd.wr_left = in_range;
                    end else if (i_mode == imm_pkg::MODE_LOAD_RIGHT) begin
                        o_cmd.wr_right = in_range;
                    end else begin
                        // undecoded mode: drop the transfer
                    end
                end
            end
            imm_pkg::ST_COMPUTE: begin
                o_cmd.rd_valid  = 1'b1;
                o_cmd.acc_first = (r_k == '0);
                o_cmd.acc_end   = k_end;
                o_cmd.last_elem = k_end && j_end && i_end;
                if (!k_end) begin
                    n_k = r_k + 1'b1;
                end else begin
                    n_k = '0;
                    if (!j_end) begin
                        n_j = r_j + 1'b1;
                    end else begin
                        n_j = '0;
                        if (!i_end) begin
                            n_i = r_i + 1'b1;
                        end else begin
                            n_i     = '0;
                            n_drain = imm_pkg::DRAIN_CYCLES - 2'd1;
                            n_state = imm_pkg::ST_DRAIN;
                        end
                    end
                end
            end
            imm_pkg::ST_DRAIN: begin
                if (r_drain == '0) begin
                    n_state = imm_pkg::ST_IDLE;
                end else begin
                    n_drain = r_drain - 2'd1;
                end
            end
            default: begin
                n_state = imm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/imm_datapath.sv
// Datapath of the matrix multiply: element stores, multiplier, accumulator, result register.
// Depends on imm_pkg; commanded by imm_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module imm_datapath #(
    parameter int MAX_DIM = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire imm_pkg::t_dp_cmd                  i_cmd,
    input  wire logic [imm_pkg::IDX_W-1:0]         i_row,
    input  wire logic [imm_pkg::IDX_W-1:0]         i_col,
    input  wire logic signed [imm_pkg::DATA_W-1:0] i_element,
    output logic                                   o_valid,
    output logic [imm_pkg::IDX_W-1:0]              o_out_row,
    output logic [imm_pkg::IDX_W-1:0]              o_out_col,
    output logic signed [imm_pkg::DATA_W-1:0]      o_product_value,
    output logic                                   o_last
);

    localparam int CELLS  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int LIN_W  = 2 * imm_pkg::IDX_W;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [imm_pkg::IDX_W-1:0] r,
                                                    input logic [imm_pkg::IDX_W-1:0] c);
        logic [LIN_W-1:0] lin;
        lin = LIN_W'({{imm_pkg::IDX_W{1'b0}}, r} * LIN_W'(MAX_DIM))
              + {{imm_pkg::IDX_W{1'b0}}, c};
        return lin[ADDR_W-1:0];
    endfunction

    logic [imm_pkg::DATA_W-1:0] mem_left  [CELLS];
    logic [imm_pkg::DATA_W-1:0] mem_right [CELLS];

    logic [ADDR_W-1:0] wr_addr, a_addr, b_addr;

    // stage 1: store read
    logic                       r_s1_valid, r_s1_first, r_s1_end, r_s1_last;
    logic [imm_pkg::IDX_W-1:0]  r_s1_i, r_s1_j;
    logic [imm_pkg::DATA_W-1:0] r_a_q, r_b_q;
    // stage 2: product
    logic                       r_s2_valid, r_s2_first, r_s2_end, r_s2_last;
    logic [imm_pkg::IDX_W-1:0]  r_s2_i, r_s2_j;
    logic [imm_pkg::DATA_W-1:0] r_prod, n_prod;
    // stage 3: accumulate and result
    logic [imm_pkg::DATA_W-1:0] r_acc, n_acc;
    logic                       r_out_valid, r_out_last;
    logic [imm_pkg::IDX_W-1:0]  r_out_row, r_out_col;
    logic [imm_pkg::DATA_W-1:0] r_out_value;

    assign wr_addr = cell_addr(i_row, i_col);
    assign a_addr  = cell_addr(i_cmd.ci, i_cmd.ck);
    assign b_addr  = cell_addr(i_cmd.ck, i_cmd.cj);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_left) begin
            mem_left[wr_addr] <= i_element;
        end
        if (i_cmd.wr_right) begin
            mem_right[wr_addr] <= i_element;
        end
        if (i_cmd.rd_valid) begin
            r_a_q <= mem_left[a_addr];
            r_b_q <= mem_right[b_addr];
        end
    end

    // Low 32 bits of the product are the same for signed and unsigned operands.
    assign n_prod = r_a_q * r_b_q;
    assign n_acc  = (r_s2_first ? '0 : r_acc) + r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= i_cmd.rd_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid && r_s2_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.acc_first;
        r_s1_end   <= i_cmd.acc_end;
        r_s1_last  <= i_cmd.last_elem;
        r_s1_i     <= i_cmd.ci;
        r_s1_j     <= i_cmd.cj;
        r_s2_first <= r_s1_first;
        r_s2_end   <= r_s1_end;
        r_s2_last  <= r_s1_last;
        r_s2_i     <= r_s1_i;
        r_s2_j     <= r_s1_j;
        r_prod     <= n_prod;
        if (r_s2_valid) begin
            r_acc       <= n_acc;
            r_out_value <= n_acc;
            r_out_row   <= r_s2_i;
            r_out_col   <= r_s2_j;
            r_out_last  <= r_s2_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_product_value = $signed(r_out_value);
    assign o_last          = r_out_valid && r_out_last;

endmodule

`default_nettype wire

// File: rtl/integer_matrix_multiply.sv
// Integer matrix multiply C = A x B, top level; uses imm_pkg, imm_ctrl, imm_datapath.
// Load transfer: busy stays low. Compute transfer: busy through the loop and drain,
// one multiply-accumulate per cycle; one result strobe per finished dot product,
// the receiver cannot stall.
// Synchronous active-low reset: idle, matrix_size = MAX_DIM, element stores unchanged.
`timescale 1ns / 1ps
`default_nettype none

module integer_matrix_multiply #(
    parameter int MAX_DIM = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // command channel: transfer at an edge with start high and busy low
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [imm_pkg::MODE_W-1:0]        i_mode,
    input  wire logic [imm_pkg::IDX_W-1:0]         i_row,
    input  wire logic [imm_pkg::IDX_W-1:0]         i_col,
    input  wire logic signed [imm_pkg::DATA_W-1:0] i_element,
    // matrix_size register write
    input  wire logic                              i_cfg_we,
    input  wire logic [imm_pkg::DIM_W-1:0]         i_cfg_data,
    // result channel: one-cycle strobe per product element, row-major order
    output logic                                   o_valid,
    output logic [imm_pkg::IDX_W-1:0]              o_out_row,
    output logic [imm_pkg::IDX_W-1:0]              o_out_col,
    output logic signed [imm_pkg::DATA_W-1:0]      o_product_value,
    output logic                                   o_last
);

    imm_pkg::t_dp_cmd cmd;

    // The controller owns the size register and the i/j/k loop; each compute
    // cycle it issues one store read pair for term k of element (i, j).
    imm_ctrl #(
        .MAX_DIM    (MAX_DIM)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_mode     (i_mode),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_busy     (busy),
        .o_cmd      (cmd)
    );

    // Three-stage datapath: registered store read, registered product,
    // accumulator that loads the result register on the final term.
    imm_datapath #(
        .MAX_DIM         (MAX_DIM)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_row           (i_row),
        .i_col           (i_col),
        .i_element       (i_element),
        .o_valid         (o_valid),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_product_value (o_product_value),
        .o_last          (o_last)
    );

`ifndef SYNTHESIS
    // The last mark only rides on a result strobe.
    a_last_with_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid)
        else $error("last mark without result strobe");

    // A transfer is only taken once the previous compute has fully drained.
    a_no_result_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid)
        else $error("result strobe right after a command transfer");

    // More results are still pending after any non-final result.
    a_busy_after_middle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> busy)
        else $error("block went idle before the final result");
`endif

endmodule

`default_nettype wire
